// ----- hdl/mobnd_pkg.sv -----
// Shared types and constants for the 3x3 mask outer-boundary streamer.
// No dependencies; used by the interfaces, the result queue and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mobnd_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int IMGW_W  = 12;
  localparam int IMGH_W  = 13;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Reset values of the geometry registers
  localparam logic [IMGW_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [IMGH_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  // Window layout: bits 2..0 left column, 5..3 center, 8..6 right;
  // within a column bit 0 is the top row.
  localparam logic [8:0] WIN_NO_CENTER = 9'h1ef;
  localparam logic [8:0] WIN_TOP_ROW   = 9'h049;
  localparam logic [8:0] WIN_BOT_ROW   = 9'h124;
  localparam logic [8:0] WIN_LEFT_COL  = 9'h007;
  localparam logic [8:0] WIN_RIGHT_COL = 9'h1c0;

  // Result queue geometry
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  // One result transaction
  typedef struct packed {
    logic             is_boundary;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
    logic             last_of_frame;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/mobnd_if.sv -----
// Valid/ready channel interfaces for mask pixels in and boundary results out.
// Depends on mobnd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mobnd_in_if;
  logic valid;
  logic ready;
  logic mask_set;
  logic flush;

  modport source (output valid, output mask_set, output flush, input ready);
  modport sink (input valid, input mask_set, input flush, output ready);
endinterface

interface mobnd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_boundary;
  logic [mobnd_pkg::COL_W-1:0] pixel_col;
  logic [mobnd_pkg::ROW_W-1:0] pixel_row;
  logic                        last_of_frame;

  modport source (output valid, output is_boundary, output pixel_col, output pixel_row,
                  output last_of_frame, input ready);
  modport sink (input valid, input is_boundary, input pixel_col, input pixel_row,
                input last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- hdl/mobnd_outq.sv -----
// Small result queue that decouples the window stage from the output handshake.
// Depends on mobnd_pkg (res_t, queue geometry).
`timescale 1ns / 1ps
`default_nettype none

module mobnd_outq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  input  wire mobnd_pkg::res_t                  push_data,
  input  wire logic                             pop_ready,
  output      logic                             pop_valid,
  output      mobnd_pkg::res_t                  pop_data,
  output      logic [mobnd_pkg::OUTQ_CNT_W-1:0] count
);

  mobnd_pkg::res_t                  entry_r [mobnd_pkg::OUTQ_DEPTH];
  logic [mobnd_pkg::OUTQ_PTR_W-1:0] wr_ptr_r;
  logic [mobnd_pkg::OUTQ_PTR_W-1:0] rd_ptr_r;
  logic [mobnd_pkg::OUTQ_CNT_W-1:0] cnt_r;
  logic [mobnd_pkg::OUTQ_CNT_W-1:0] cnt_nxt;
  logic                             pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = cnt_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // payload storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mask_outer_boundary_3x3_core.sv -----
// Results: the result for pixel (r, c) is valid after the input transaction at
// raster position r*W + c + W + 1 is accepted; the first W + 1 transactions give no result.
// Throughput: one pixel per cycle while the result queue has room; the line memory reads
// at accept and writes back the next cycle on its second port, same-entry overlap forwarded.
// Reset: counters, window, pipeline, result queue clear, geometry 640x480; line memory kept.
// Depends on mobnd_pkg, mobnd_if and mobnd_outq.
`timescale 1ns / 1ps
`default_nettype none

module mask_outer_boundary_3x3_core #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  mobnd_in_if.sink                               in_s,
  mobnd_out_if.source                            out_m,
  input  wire logic                              cfg_we,
  input  wire logic [mobnd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mobnd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);      // column index
  localparam int ORW = $clog2(MAX_HEIGHT);     // output row
  localparam int IRW = $clog2(MAX_HEIGHT + 2); // input row, runs into the drain

  // clamp a width register to its last column index
  function automatic logic [CW-1:0] width_last(input logic [mobnd_pkg::IMGW_W-1:0] v);
    logic [CW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_WIDTH) begin
      res = CW'(MAX_WIDTH - 1);
    end else begin
      res = CW'(int'(v) - 1);
    end
    return res;
  endfunction

  // clamp a height register to its last row index
  function automatic logic [ORW-1:0] height_last(input logic [mobnd_pkg::IMGH_W-1:0] v);
    logic [ORW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_HEIGHT) begin
      res = ORW'(MAX_HEIGHT - 1);
    end else begin
      res = ORW'(int'(v) - 1);
    end
    return res;
  endfunction

  // geometry
  logic [CW-1:0]  wlast_r;
  logic [ORW-1:0] hlast_r;

  // frame counters (accept side)
  logic [CW-1:0]  in_col_r;
  logic [IRW-1:0] in_row_r;
  logic [CW-1:0]  out_col_r;
  logic [ORW-1:0] out_row_r;

  // accept-side decode
  logic acc;
  logic pix;
  logic started;
  logic in_col_end;
  logic at_top;
  logic at_bot;
  logic at_left;
  logic at_right;
  logic at_last;

  // window stage
  logic           s1_v_r;
  logic [CW-1:0]  s1_col_r;
  logic           s1_pix_r;
  logic           s1_started_r;
  logic           s1_top_r;
  logic           s1_bot_r;
  logic           s1_left_r;
  logic           s1_right_r;
  logic           s1_last_r;
  logic [CW-1:0]  s1_ocol_r;
  logic [ORW-1:0] s1_orow_r;
  logic [1:0]     rdq_r;        // [1] upper line, [0] middle line
  logic [1:0]     wr_data;
  logic [8:0]     win_r;
  logic [8:0]     win_nxt;
  logic [8:0]     allow;
  logic           push;
  mobnd_pkg::res_t push_res;

  // line memory: bit 1 upper line, bit 0 middle line
  logic [1:0] line_mem [MAX_WIDTH];

  // result queue status
  logic [mobnd_pkg::OUTQ_CNT_W-1:0] q_cnt;
  logic [mobnd_pkg::OUTQ_CNT_W-1:0] q_load;
  mobnd_pkg::res_t                  q_data;

  // room for the transaction now in the window stage and one more
  assign q_load     = q_cnt + mobnd_pkg::OUTQ_CNT_W'(s1_v_r);
  assign in_s.ready = (q_load < mobnd_pkg::OUTQ_CNT_W'(mobnd_pkg::OUTQ_DEPTH));
  assign acc        = in_s.valid && in_s.ready;

  // pixel and position decode at accept
  always_comb begin
    pix        = in_s.mask_set && !in_s.flush && (in_row_r <= IRW'(hlast_r));
    started    = (in_row_r >= IRW'(2)) || ((in_row_r == IRW'(1)) && (in_col_r != '0));
    in_col_end = (in_col_r == wlast_r);
    at_top     = (out_row_r == '0);
    at_bot     = (out_row_r == hlast_r);
    at_left    = (out_col_r == '0);
    at_right   = (out_col_r == wlast_r);
    at_last    = at_bot && at_right;
  end

  // geometry registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= width_last(mobnd_pkg::IMAGE_WIDTH_RST);
      hlast_r <= height_last(mobnd_pkg::IMAGE_HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        mobnd_pkg::REG_IMAGE_WIDTH: begin
          wlast_r <= width_last(cfg_data[mobnd_pkg::IMGW_W-1:0]);
        end
        mobnd_pkg::REG_IMAGE_HEIGHT: begin
          hlast_r <= height_last(cfg_data[mobnd_pkg::IMGH_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // frame counters; the final result of a frame, reset or a configuration write restarts them
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (acc) begin
      if (started && at_last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (in_col_end) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        if (started) begin
          if (at_right) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + 1'b1;
          end else begin
            out_col_r <= out_col_r + 1'b1;
          end
        end
      end
    end
  end

  // window stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  // window stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r     <= in_col_r;
      s1_pix_r     <= pix;
      s1_started_r <= started;
      s1_top_r     <= at_top;
      s1_bot_r     <= at_bot;
      s1_left_r    <= at_left;
      s1_right_r   <= at_right;
      s1_last_r    <= at_last;
      s1_ocol_r    <= out_col_r;
      s1_orow_r    <= out_row_r;
    end
  end

  // shift the middle line up, store the new pixel as middle
  assign wr_data = {rdq_r[0], s1_pix_r};

  // line memory: write back from the window stage, read at accept with forwarding
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_mem[s1_col_r] <= wr_data;
    end
    if (acc) begin
      if (s1_v_r && (s1_col_r == in_col_r)) begin
        rdq_r <= wr_data;
      end else begin
        rdq_r <= line_mem[in_col_r];
      end
    end
  end

  // new window column enters on the right
  always_comb begin
    win_nxt = {s1_pix_r, rdq_r[0], rdq_r[1], win_r[8:3]};
    allow   = mobnd_pkg::WIN_NO_CENTER;
    if (s1_top_r) begin
      allow = allow & ~mobnd_pkg::WIN_TOP_ROW;
    end
    if (s1_bot_r) begin
      allow = allow & ~mobnd_pkg::WIN_BOT_ROW;
    end
    if (s1_left_r) begin
      allow = allow & ~mobnd_pkg::WIN_LEFT_COL;
    end
    if (s1_right_r) begin
      allow = allow & ~mobnd_pkg::WIN_RIGHT_COL;
    end
    push_res.is_boundary   = !win_nxt[4] && ((win_nxt & allow) != '0);
    push_res.pixel_col     = mobnd_pkg::COL_W'(s1_ocol_r);
    push_res.pixel_row     = mobnd_pkg::ROW_W'(s1_orow_r);
    push_res.last_of_frame = s1_last_r;
    push = s1_v_r && s1_started_r;
  end

  // window register; cleared by reset, a configuration write or the final result of a frame
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      win_r <= '0;
    end else if (s1_v_r) begin
      if (s1_started_r && s1_last_r) begin
        win_r <= '0;
      end else begin
        win_r <= win_nxt;
      end
    end
  end

  mobnd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_res),
    .pop_ready (out_m.ready),
    .pop_valid (out_m.valid),
    .pop_data  (q_data),
    .count     (q_cnt)
  );

  assign out_m.is_boundary   = q_data.is_boundary;
  assign out_m.pixel_col     = q_data.pixel_col;
  assign out_m.pixel_row     = q_data.pixel_row;
  assign out_m.last_of_frame = q_data.last_of_frame;

  // queue never overruns with the stage in flight
  a_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_load <= mobnd_pkg::OUTQ_CNT_W'(mobnd_pkg::OUTQ_DEPTH))
    else $error("result queue overrun");

  // column counters stay within the configured width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_col_r <= wlast_r) && (out_col_r <= wlast_r))
    else $error("column counter beyond image width");

  // final result of a frame restarts all counters
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && started && at_last && !cfg_we) |=>
      (in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0))
    else $error("frame did not restart after its final result");

  // window stage writes back the transaction read in the cycle before
  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_v_r && (s1_col_r == $past(in_col_r)))
    else $error("window stage lost a transaction");

endmodule

`default_nettype wire
